FILE: hw/rtl/box_range_record_filter_assert.svh
// Assertion macros shared by the box range record filter RTL.
// Expects signals clk and arst_n in the including module.
`ifndef BOX_RANGE_RECORD_FILTER_ASSERT_SVH
`define BOX_RANGE_RECORD_FILTER_ASSERT_SVH

// check cons in the same cycle as ante
`define BRRF_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check cons in the cycle after ante
`define BRRF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/brrf_pkg.sv
// Package for the box range record filter: widths, codes and bundle types.
// No dependencies.
`default_nettype none

package brrf_pkg;

	localparam int DIMS      = 4;
	localparam int VAL_W     = 16;
	localparam int DIM_W     = 2;
	localparam int ID_W      = 16;
	localparam int FACT_W    = 16;
	localparam int EXT_W     = 16;
	localparam int EXT_FRAC  = 12;
	localparam int REL_FRAC  = 15;
	localparam int RAD_W     = 24;
	localparam int SCL_W     = 21;
	localparam int SQ_W      = 34;
	localparam int NDIM_W    = 3;
	localparam int CFG_AW    = 6;
	localparam int CFG_DW    = 64;
	localparam int REG_IDX_W = 3;

	typedef enum logic [1:0] {
		METH_SHARED  = 2'd0,
		METH_MAXDIFF = 2'd1,
		METH_REL_FAR = 2'd2,
		METH_ABS_FAR = 2'd3
	} method_t;

	localparam logic ITEM_RECORD = 1'b0;
	localparam logic ITEM_FINISH = 1'b1;

	localparam logic [1:0] KIND_SEL    = 2'd0;
	localparam logic [1:0] KIND_RADIUS = 2'd1;
	localparam logic [1:0] KIND_FEW    = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_METHOD = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_POINT  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_FACTOR = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_EXT    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_DIMS   = 3'd4;

	localparam method_t              RST_METHOD = METH_MAXDIFF;
	localparam logic [EXT_W-1:0]     RST_EXT    = 16'd4096;
	localparam logic [NDIM_W-1:0]    RST_DIMS   = 3'd4;

	typedef struct packed {
		logic                    item_kind;
		logic [ID_W-1:0]         record_id;
		logic signed [VAL_W-1:0] value_dim0;
		logic signed [VAL_W-1:0] value_dim1;
		logic signed [VAL_W-1:0] value_dim2;
		logic signed [VAL_W-1:0] value_dim3;
	} rec_item_t;

	typedef struct packed {
		logic [1:0]              result_kind;
		logic [ID_W-1:0]         selected_id;
		logic [DIM_W-1:0]        radius_dim;
		logic signed [RAD_W-1:0] radius_value;
		logic                    last_of_run;
	} res_item_t;

	typedef struct packed {
		method_t                method;
		logic [CFG_DW-1:0]      query_point;
		logic [CFG_DW-1:0]      range_factors;
		logic [EXT_W-1:0]       ext_factor;
		logic [NDIM_W-1:0]      dims_in_use;
	} cfg_t;

	typedef struct packed {
		logic                         valid;
		logic [1:0]                   kind;
		logic [ID_W-1:0]              id;
		logic [DIMS-1:0][RAD_W-1:0]   rad;
		logic [DIM_W-1:0]             last_idx;
	} load_t;

endpackage

`default_nettype wire

FILE: hw/rtl/brrf_cfg.sv
// Configuration register file of the box range record filter (APB-style port).
// Depends on brrf_pkg.
`default_nettype none

module brrf_cfg
	import brrf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [CFG_AW-1:0] paddr,
	input  wire logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0]      prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	method_t           method_q;
	logic [CFG_DW-1:0] point_q;
	logic [CFG_DW-1:0] factor_q;
	logic [EXT_W-1:0]  ext_q;
	logic [NDIM_W-1:0] dims_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic              wr_en;

	assign reg_idx = paddr[CFG_AW-1:CFG_AW-REG_IDX_W];
	assign wr_en   = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_q <= RST_METHOD;
			point_q  <= '0;
			factor_q <= '0;
			ext_q    <= RST_EXT;
			dims_q   <= RST_DIMS;
		end else if (wr_en) begin
			case (reg_idx)
				REG_METHOD: method_q <= method_t'(pwdata[1:0]);
				REG_POINT:  point_q  <= pwdata;
				REG_FACTOR: factor_q <= pwdata;
				REG_EXT:    ext_q    <= pwdata[EXT_W-1:0];
				REG_DIMS:   dims_q   <= pwdata[NDIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_METHOD: prdata = {{(CFG_DW-2){1'b0}}, method_q};
			REG_POINT:  prdata = point_q;
			REG_FACTOR: prdata = factor_q;
			REG_EXT:    prdata = {{(CFG_DW-EXT_W){1'b0}}, ext_q};
			REG_DIMS:   prdata = {{(CFG_DW-NDIM_W){1'b0}}, dims_q};
			default:    prdata = '0;
		endcase
	end

	assign cfg.method        = method_q;
	assign cfg.query_point   = point_q;
	assign cfg.range_factors = factor_q;
	assign cfg.ext_factor    = ext_q;
	assign cfg.dims_in_use   = dims_q;

endmodule

`default_nettype wire

FILE: hw/rtl/brrf_eval.sv
// Input register, box test, radius datapath and query state of the filter.
// Depends on brrf_pkg and box_range_record_filter_assert.svh.
`default_nettype none
`include "box_range_record_filter_assert.svh"

module brrf_eval
	import brrf_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cfg_t      cfg,
	input  wire logic      rec_valid,
	output logic           rec_stall,
	input  wire rec_item_t rec_data,
	input  wire logic      can_load,
	output load_t          load
);

	rec_item_t d_s1;
	logic      v_s1;

	logic [1:0]       cnt_q;
	logic [SCL_W-1:0] max_q [DIMS];
	logic [SQ_W-1:0]  far_sq_q;
	logic [VAL_W-1:0] far_diff_q [DIMS];

	logic signed [VAL_W-1:0] val [DIMS];
	logic [VAL_W-1:0]        absd [DIMS];
	logic [SCL_W-1:0]        scaled [DIMS];
	logic [2*VAL_W-1:0]      sq [DIMS];
	logic [RAD_W-1:0]        radius [DIMS];
	logic [DIMS-1:0]         ok;
	logic [DIMS-1:0]         act;
	logic [NDIM_W-1:0]       nd;
	logic [SQ_W-1:0]         sq_sum;
	logic                    finishing;
	logic                    drop;
	logic                    take;
	logic                    few;

	assign val[0] = d_s1.value_dim0;
	assign val[1] = d_s1.value_dim1;
	assign val[2] = d_s1.value_dim2;
	assign val[3] = d_s1.value_dim3;

	always_comb begin
		if (cfg.dims_in_use == '0) begin
			nd = NDIM_W'(1);
		end else if (cfg.dims_in_use > NDIM_W'(DIMS)) begin
			nd = NDIM_W'(DIMS);
		end else begin
			nd = cfg.dims_in_use;
		end
	end

	assign finishing = (d_s1.item_kind == ITEM_FINISH);

	for (genvar g = 0; g < DIMS; g++) begin : g_dim
		logic signed [VAL_W-1:0] q;
		logic [FACT_W-1:0]       f_d;
		logic [FACT_W-1:0]       fsel;
		logic [2*VAL_W:0]        prod;
		logic signed [VAL_W:0]   e;
		logic signed [VAL_W:0]   neg_e;
		logic                    in_rel;
		logic                    in_abs;
		logic [VAL_W-1:0]        mop;
		logic [VAL_W+EXT_W-1:0]  mp;
		logic [VAL_W+EXT_W:0]    sr;
		logic [2*VAL_W+1:0]      hw_sum;

		assign q     = cfg.query_point[g*VAL_W +: VAL_W];
		assign f_d   = cfg.range_factors[g*FACT_W +: FACT_W];
		assign fsel  = (cfg.method == METH_SHARED) ? cfg.range_factors[FACT_W-1:0] : f_d;
		assign prod  = (2*VAL_W+1)'($signed(q) * $signed({1'b0, fsel}));
		assign e     = $signed({val[g][VAL_W-1], val[g]}) - $signed({q[VAL_W-1], q});
		assign neg_e = -e;
		assign absd[g] = e[VAL_W] ? neg_e[VAL_W-1:0] : e[VAL_W-1:0];

		assign in_rel = !prod[2*VAL_W] &&
			({2'b00, absd[g], {REL_FRAC{1'b0}}} <= prod);
		assign in_abs = (absd[g] <= fsel);
		assign act[g] = (NDIM_W'(g) < nd);
		assign ok[g]  = !act[g] || ((cfg.method == METH_ABS_FAR) ? in_abs : in_rel);

		assign mop = finishing ? far_diff_q[g] : absd[g];
		assign mp  = mop * cfg.ext_factor;
		assign sr  = {1'b0, mp} + (VAL_W+EXT_W+1)'(1 << (EXT_FRAC - 1));
		assign scaled[g] = sr[EXT_FRAC +: SCL_W];

		assign sq[g] = act[g] ? absd[g] * absd[g] : '0;

		assign hw_sum = {prod[2*VAL_W], prod} + (2*VAL_W+2)'(1 << (REL_FRAC - 1));

		always_comb begin
			case (cfg.method)
				METH_SHARED: radius[g] = RAD_W'($signed(hw_sum[2*VAL_W+1:REL_FRAC]));
				METH_MAXDIFF: radius[g] = RAD_W'(max_q[g]);
				default:     radius[g] = RAD_W'(scaled[g]);
			endcase
		end
	end

	assign sq_sum = SQ_W'(sq[0]) + SQ_W'(sq[1]) + SQ_W'(sq[2]) + SQ_W'(sq[3]);

	assign few  = (cfg.method != METH_SHARED) && (cnt_q < 2'd2);
	assign drop = v_s1 && !finishing && !(&ok);
	assign take = v_s1 && (drop || can_load);
	assign rec_stall = v_s1 && !take;

	always_comb begin
		load.valid = v_s1 && !drop && can_load;
		if (!finishing) begin
			load.kind     = KIND_SEL;
			load.id       = d_s1.record_id;
			load.rad      = '0;
			load.last_idx = '0;
		end else if (few) begin
			load.kind     = KIND_FEW;
			load.id       = '0;
			load.rad      = '0;
			load.last_idx = '0;
		end else begin
			load.kind     = KIND_RADIUS;
			load.id       = '0;
			for (int d = 0; d < DIMS; d++) begin
				load.rad[d] = radius[d];
			end
			load.last_idx = DIM_W'(nd - NDIM_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rec_valid && !rec_stall) begin
			v_s1 <= 1'b1;
		end else if (take) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_valid && !rec_stall) begin
			d_s1 <= rec_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			far_sq_q <= '0;
			for (int d = 0; d < DIMS; d++) begin
				max_q[d]      <= '0;
				far_diff_q[d] <= '0;
			end
		end else if (take && finishing) begin
			cnt_q    <= '0;
			far_sq_q <= '0;
			for (int d = 0; d < DIMS; d++) begin
				max_q[d]      <= '0;
				far_diff_q[d] <= '0;
			end
		end else if (take && !drop) begin
			if (cnt_q != 2'd2) begin
				cnt_q <= cnt_q + 2'd1;
			end
			for (int d = 0; d < DIMS; d++) begin
				if (act[d] && (scaled[d] > max_q[d])) begin
					max_q[d] <= scaled[d];
				end
			end
			if (sq_sum > far_sq_q) begin
				far_sq_q <= sq_sum;
				for (int d = 0; d < DIMS; d++) begin
					far_diff_q[d] <= act[d] ? absd[d] : '0;
				end
			end
		end
	end

	`BRRF_ASSERT_SAME(a_cnt_sat, 1'b1, cnt_q != 2'd3, "selected count past saturation")
	`BRRF_ASSERT_NEXT(a_finish_clears, take && finishing,
		cnt_q == '0 && far_sq_q == '0, "query state not cleared after finish")
	`BRRF_ASSERT_NEXT(a_drop_keeps, drop,
		$stable(cnt_q) && $stable(far_sq_q), "rejected record changed query state")

endmodule

`default_nettype wire

FILE: hw/rtl/brrf_out.sv
// Result register and sequencer: emits one result per cycle while res is not stalled, radii in dimension order.
// Depends on brrf_pkg and box_range_record_filter_assert.svh.
`default_nettype none
`include "box_range_record_filter_assert.svh"

module brrf_out
	import brrf_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire load_t load,
	output logic       can_load,
	output logic       res_valid,
	input  wire logic  res_stall,
	output res_item_t  res_data
);

	logic             busy_q;
	logic [DIM_W-1:0] idx_q;
	logic [1:0]       kind_q;
	logic [ID_W-1:0]  id_q;
	logic [RAD_W-1:0] rad_q [DIMS];
	logic [DIM_W-1:0] last_q;
	logic             fire;
	logic             is_last;

	assign fire     = busy_q && !res_stall;
	assign is_last  = (idx_q == last_q);
	assign can_load = !busy_q || (fire && is_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load.valid) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (fire) begin
			if (is_last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + DIM_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load.valid) begin
			kind_q <= load.kind;
			id_q   <= load.id;
			last_q <= load.last_idx;
			for (int d = 0; d < DIMS; d++) begin
				rad_q[d] <= load.rad[d];
			end
		end
	end

	assign res_valid             = busy_q;
	assign res_data.result_kind  = kind_q;
	assign res_data.selected_id  = id_q;
	assign res_data.radius_dim   = (kind_q == KIND_RADIUS) ? idx_q : '0;
	assign res_data.radius_value = $signed(rad_q[idx_q]);
	assign res_data.last_of_run  = is_last;

	`BRRF_ASSERT_SAME(a_idx_bound, busy_q, idx_q <= last_q, "result index past last")
	`BRRF_ASSERT_NEXT(a_idx_step, fire && !is_last,
		busy_q && idx_q == $past(idx_q) + DIM_W'(1), "radius sequence skipped")
	`BRRF_ASSERT_SAME(a_single, busy_q && kind_q != KIND_RADIUS, last_q == '0,
		"single result run longer than one")

endmodule

`default_nettype wire

FILE: hw/rtl/box_range_record_filter.sv
// Box range record filter: selects records inside a query box and reports radii.
// Channels: rec (request in) and res (result out), each valid/stall; config via APB.
// Throughput: one request per cycle while res is not stalled; a finish request holds
// the single result register until its last result is taken.
// An accepted request passes through the input register and then the result register
// before its first result shows on res.
// Record: one selected-id result if inside the box, none if rejected.
// Finish: one radius per compared dimension in dimension order, or one
// too-few-selected result; last_of_run marks the final result; query state clears.
// Reset: registers take their reset values, query state clears, no result pending.
// A stall on res holds the current result; rec stalls only while the input register
// holds a request that cannot move into the result register.
// Config writes go in at the APB access edge and must be made while idle.
// Depends on brrf_pkg, brrf_cfg, brrf_eval, brrf_out.
`default_nettype none

module box_range_record_filter
	import brrf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rec_valid,
	output logic                   rec_stall,
	input  wire rec_item_t         rec_data,
	output logic                   res_valid,
	input  wire logic              res_stall,
	output res_item_t              res_data,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [CFG_AW-1:0] paddr,
	input  wire logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0]      prdata,
	output logic                   pready
);

	cfg_t  cfg;
	load_t load;
	logic  can_load;

	brrf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	brrf_eval u_eval (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.rec_valid (rec_valid),
		.rec_stall (rec_stall),
		.rec_data  (rec_data),
		.can_load  (can_load),
		.load      (load)
	);

	brrf_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.can_load  (can_load),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule

`default_nettype wire
